>>> rtl/core/grsum_pkg.sv
// Package with shared constants, codes and types of the grouped running sum block.
`timescale 1ns / 1ps
`default_nettype none
package grsum_pkg;

    localparam int NUM_GROUPS = 256;
    localparam int GIDX_W     = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

    localparam int VALUE_W    = 32;
    localparam int GROUP_W    = 8;
    localparam int SLOT_W     = 31;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [VALUE_W-1:0] NA_CODE = 32'h8000_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_NA_MODE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUPED = 8'd1;

    localparam logic [1:0] NA_PROPAGATE = 2'd0;
    localparam logic [1:0] NA_SKIP      = 2'd1;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_CALC = 1'b1
    } state_t;

    typedef struct packed {
        logic load;    // capture the input beat and read the group memory
        logic commit;  // compute, write back and load the output register
    } dp_cmd_t;

endpackage
`default_nettype wire

>>> rtl/core/grsum_ctrl.sv
// Controller state machine of the grouped running sum block.
`timescale 1ns / 1ps
`default_nettype none
module grsum_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output grsum_pkg::dp_cmd_t     cmd
);

    grsum_pkg::state_t state_reg, state_next;
    logic              m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= grsum_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd.load     = 1'b0;
        cmd.commit   = 1'b0;
        s_ready      = 1'b0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            grsum_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = grsum_pkg::ST_CALC;
                end
            end
            grsum_pkg::ST_CALC: begin
                // The result may only land once the output register is free.
                if (!m_valid_reg || m_ready) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = grsum_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = grsum_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

>>> rtl/core/grsum_datapath.sv
// Datapath of the grouped running sum block: configuration, group memory and result logic.
`timescale 1ns / 1ps
`default_nettype none
module grsum_datapath (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire grsum_pkg::dp_cmd_t                   cmd,
    input  wire logic                                 cfg_we,
    input  wire logic [grsum_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [grsum_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic signed [grsum_pkg::VALUE_W-1:0] s_value,
    input  wire logic [grsum_pkg::GROUP_W-1:0]        s_group,
    input  wire logic                                 s_start_req,
    input  wire logic [grsum_pkg::SLOT_W-1:0]         s_slot,
    output logic signed [grsum_pkg::VALUE_W-1:0]      m_sum,
    output logic                                      m_overflow,
    output logic [grsum_pkg::SLOT_W-1:0]              m_slot_out
);

    localparam int VW = grsum_pkg::VALUE_W;
    localparam int GW = grsum_pkg::GIDX_W;
    localparam int NG = grsum_pkg::NUM_GROUPS;

    logic [1:0] na_mode_reg;
    logic       grouped_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            na_mode_reg <= grsum_pkg::NA_PROPAGATE;
            grouped_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                grsum_pkg::CFG_NA_MODE: na_mode_reg <= cfg_data[1:0];
                grsum_pkg::CFG_GROUPED: grouped_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Group index of the incoming beat, saturated to the last group; group 0 when grouping is off.
    logic [GW-1:0] gidx_in;
    always_comb begin
        if (!grouped_reg) begin
            gidx_in = '0;
        end else if (32'(s_group) >= 32'(NG)) begin
            gidx_in = GW'(NG - 1);
        end else begin
            gidx_in = GW'(s_group);
        end
    end

    // Each memory word holds the sticky missing mark above the carried sum.
    logic [VW:0]          mem [NG];
    logic [VW:0]          rd_reg;
    logic [NG-1:0]        valid_reg;
    logic [VW-1:0]        value_reg;
    logic [GW-1:0]        gidx_reg;
    logic [grsum_pkg::SLOT_W-1:0] slot_reg;

    logic          wr_en;
    logic [VW:0]   wr_word;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rd_reg    <= mem[gidx_in];
            value_reg <= s_value;
            gidx_reg  <= gidx_in;
            slot_reg  <= s_slot;
        end
        if (cmd.commit && wr_en) begin
            mem[gidx_reg] <= wr_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.load && s_start_req) begin
            valid_reg <= '0;
        end else if (cmd.commit && wr_en) begin
            valid_reg[gidx_reg] <= 1'b1;
        end
    end

    logic          entry_valid;
    logic [VW-1:0] total;
    logic          miss;
    logic          is_na;
    logic [VW:0]   sum_wide;
    logic          sum_ovf;
    logic [VW-1:0] res;
    logic          ovf;

    always_comb begin
        entry_valid = valid_reg[gidx_reg];
        total       = entry_valid ? rd_reg[VW-1:0] : '0;
        miss        = entry_valid & rd_reg[VW];
        is_na       = (value_reg == grsum_pkg::NA_CODE);
        sum_wide    = {total[VW-1], total} + {value_reg[VW-1], value_reg};
        // Out of range when the 33-bit sum does not fit, or lands on the missing code.
        sum_ovf     = (sum_wide[VW] != sum_wide[VW-1]) ||
                      (sum_wide[VW-1:0] == grsum_pkg::NA_CODE);
        res         = grsum_pkg::NA_CODE;
        ovf         = 1'b0;
        wr_en       = 1'b0;
        wr_word     = {1'b0, sum_wide[VW-1:0]};
        if (miss) begin
            res = grsum_pkg::NA_CODE;
        end else if (is_na) begin
            case (na_mode_reg)
                grsum_pkg::NA_PROPAGATE: begin
                    wr_en   = 1'b1;
                    wr_word = {1'b1, total};
                end
                grsum_pkg::NA_SKIP: begin
                    res = grsum_pkg::NA_CODE;
                end
                default: begin
                    res = total;
                end
            endcase
        end else if (sum_ovf) begin
            ovf = 1'b1;
        end else begin
            res   = sum_wide[VW-1:0];
            wr_en = 1'b1;
        end
    end

    logic [VW-1:0]                sum_out_reg;
    logic                         ovf_out_reg;
    logic [grsum_pkg::SLOT_W-1:0] slot_out_reg;

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            sum_out_reg  <= res;
            ovf_out_reg  <= ovf;
            slot_out_reg <= slot_reg;
        end
    end

    assign m_sum      = sum_out_reg;
    assign m_overflow = ovf_out_reg;
    assign m_slot_out = slot_out_reg;

endmodule
`default_nettype wire

>>> rtl/core/grouped_running_sum_int_na_core.sv
// Top level of the grouped running sum block.
// Keeps one signed 32-bit running sum per group (256 groups) and returns, for every input
// beat, the updated sum of its group or the missing code, with the slot tag echoed. The
// accepting edge reads the group-sum memory into a register; once the output register is
// free, a later edge adds, checks range, writes the entry back and loads the output
// register. A new beat is taken only after that, so a beat is not accepted while the
// last is in progress; the pace is set by the registered memory read ahead of the
// read-modify-write. The output register lets the next beat enter while a result waits. A
// start request clears all groups at once through per-group valid bits; there is no clearing
// pass after reset. Configuration writes are always taken and must be issued only while idle.
`timescale 1ns / 1ps
`default_nettype none
module grouped_running_sum_int_na_core (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [grsum_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [grsum_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic signed [grsum_pkg::VALUE_W-1:0] s_value,
    input  wire logic [grsum_pkg::GROUP_W-1:0]        s_group,
    input  wire logic                                 s_start_req,
    input  wire logic [grsum_pkg::SLOT_W-1:0]         s_slot,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed [grsum_pkg::VALUE_W-1:0]      m_sum,
    output logic                                      m_overflow,
    output logic [grsum_pkg::SLOT_W-1:0]              m_slot_out
);

    grsum_pkg::dp_cmd_t cmd;

    assign cfg_ready = 1'b1;

    grsum_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    grsum_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .cfg_we      (cfg_valid & cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_value     (s_value),
        .s_group     (s_group),
        .s_start_req (s_start_req),
        .s_slot      (s_slot),
        .m_sum       (m_sum),
        .m_overflow  (m_overflow),
        .m_slot_out  (m_slot_out)
    );

endmodule
`default_nettype wire

>>> rtl/core/grsum_checker.sv
// Port-level checker of the grouped running sum block and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
module grsum_checker (
    input wire logic                                 aclk,
    input wire logic                                 aresetn,
    input wire logic                                 s_valid,
    input wire logic                                 s_ready,
    input wire logic                                 m_valid,
    input wire logic                                 m_ready,
    input wire logic signed [grsum_pkg::VALUE_W-1:0] m_sum,
    input wire logic                                 m_overflow,
    input wire logic [grsum_pkg::SLOT_W-1:0]         m_slot_out
);

    // A stalled result beat keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sum) && $stable(m_slot_out)
            && $stable(m_overflow))
        else $error("result beat changed while stalled");

    // An overflow result always carries the missing code.
    a_ovf_na: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflow |-> m_sum == grsum_pkg::NA_CODE)
        else $error("overflow result without missing code");

    // The block works on one item at a time.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while an item is in progress");

endmodule

bind grouped_running_sum_int_na_core grsum_checker u_chk (.*);
`default_nettype wire

>>> verif/grouped_running_sum_int_na_core_tb.sv
// Self-checking testbench: directed and random beats against a per-group running-sum predictor.
`timescale 1ns / 1ps
module grouped_running_sum_int_na_core_tb;
    import grsum_pkg::*;

    localparam logic [1:0]  NA_FILL      = 2'd2;
    localparam logic [1:0]  NA_FILL_ALT  = 2'd3;   // unused code, behaves as fill
    localparam longint      SUM_LIMIT    = 64'sd2147483647;
    localparam int          DIR_ROWS     = 25;
    localparam int          NUM_PHASES   = 8;
    localparam int          PHASE_ITEMS  = 128;
    localparam int          HOLD_CYCLES  = 90;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [VALUE_W-1:0] sum;
        logic               ovf;
        logic [SLOT_W-1:0]  slot;
    } sum_result_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic               grp_en;
        logic [VALUE_W-1:0] value;
        logic [GROUP_W-1:0] group;
        logic               start;
        logic [SLOT_W-1:0]  slot;
        logic               typed;
        logic [VALUE_W-1:0] sum;
        logic               ovf;
    } stim_row_t;

    logic                         aclk;
    logic                         aresetn     = 1'b0;
    logic                         cfg_valid   = 1'b0;
    logic                         cfg_ready;
    logic [CFG_IDX_W-1:0]         cfg_index   = '0;
    logic [CFG_DATA_W-1:0]        cfg_data    = '0;
    logic                         s_valid     = 1'b0;
    logic                         s_ready;
    logic signed [VALUE_W-1:0]    s_value     = '0;
    logic [GROUP_W-1:0]           s_group     = '0;
    logic                         s_start_req = 1'b0;
    logic [SLOT_W-1:0]            s_slot      = '0;
    logic                         m_valid;
    logic                         m_ready     = 1'b0;
    logic signed [VALUE_W-1:0]    m_sum;
    logic                         m_overflow;
    logic [SLOT_W-1:0]            m_slot_out;

    // Predictor state and its copy of the configuration.
    logic [VALUE_W-1:0]    grp_total [NUM_GROUPS];
    logic [NUM_GROUPS-1:0] grp_missing  = '0;
    logic [NUM_GROUPS-1:0] grp_live     = '0;
    logic [1:0]            na_policy    = NA_PROPAGATE;
    logic                  group_enable = 1'b0;

    sum_result_t pending_sums [$];
    sum_result_t oldest_sum;

    bit          hold_off_req    = 1'b0;
    int          mismatch_count  = 0;
    int          beats_sent      = 0;
    int          results_checked = 0;
    int          overflow_seen   = 0;
    int          missing_seen    = 0;
    int          reg_writes      = 0;
    int          settings_used   = 0;
    int          holds_done      = 0;
    int unsigned cycle_count     = 0;

    stim_row_t dir_rows [DIR_ROWS] = '{
        '{NA_PROPAGATE, 1'b0, 32'd5,         8'd200, 1'b0, 31'd0,          1'b1, 32'd5,         1'b0},
        '{NA_PROPAGATE, 1'b0, 32'h7FFF_FFFA, 8'd0,   1'b0, 31'h7FFF_FFFF,  1'b1, 32'h7FFF_FFFF, 1'b0},
        '{NA_PROPAGATE, 1'b0, 32'd1,         8'd0,   1'b0, 31'd1,          1'b1, NA_CODE,       1'b1},
        '{NA_PROPAGATE, 1'b0, NA_CODE,       8'd0,   1'b0, 31'd2,          1'b1, NA_CODE,       1'b0},
        '{NA_PROPAGATE, 1'b0, 32'd3,         8'd0,   1'b0, 31'd3,          1'b1, NA_CODE,       1'b0},
        '{NA_PROPAGATE, 1'b0, 32'hFFFF_FFF9, 8'd0,   1'b1, 31'd4,          1'b1, 32'hFFFF_FFF9, 1'b0},
        '{NA_PROPAGATE, 1'b0, 32'h8000_0001, 8'd0,   1'b0, 31'd5,          1'b1, NA_CODE,       1'b1},
        '{NA_PROPAGATE, 1'b0, 32'h8000_0001, 8'd0,   1'b1, 31'd6,          1'b1, 32'h8000_0001, 1'b0},
        '{NA_PROPAGATE, 1'b0, 32'hFFFF_FFFF, 8'd0,   1'b0, 31'd7,          1'b1, NA_CODE,       1'b1},
        '{NA_SKIP,      1'b1, 32'd100,       8'd255, 1'b1, 31'd8,          1'b1, 32'd100,       1'b0},
        '{NA_SKIP,      1'b1, NA_CODE,       8'd255, 1'b0, 31'd9,          1'b1, NA_CODE,       1'b0},
        '{NA_SKIP,      1'b1, 32'd1,         8'd255, 1'b0, 31'd10,         1'b1, 32'd101,       1'b0},
        '{NA_SKIP,      1'b1, 32'h7FFF_FFFF, 8'd0,   1'b0, 31'd11,         1'b1, 32'h7FFF_FFFF, 1'b0},
        '{NA_SKIP,      1'b1, 32'h7FFF_FFFF, 8'd0,   1'b0, 31'd12,         1'b1, NA_CODE,       1'b1},
        '{NA_FILL,      1'b1, NA_CODE,       8'd255, 1'b0, 31'd13,         1'b1, 32'd101,       1'b0},
        '{NA_FILL,      1'b1, NA_CODE,       8'd7,   1'b0, 31'd14,         1'b1, 32'd0,         1'b0},
        '{NA_FILL,      1'b1, 32'hFFFF_FFCE, 8'd7,   1'b0, 31'd15,         1'b1, 32'hFFFF_FFCE, 1'b0},
        '{NA_PROPAGATE, 1'b1, NA_CODE,       8'd7,   1'b0, 31'd16,         1'b1, NA_CODE,       1'b0},
        '{NA_FILL,      1'b1, 32'd10,        8'd7,   1'b0, 31'd17,         1'b1, NA_CODE,       1'b0},
        '{NA_FILL,      1'b1, NA_CODE,       8'd7,   1'b0, 31'd18,         1'b1, NA_CODE,       1'b0},
        '{NA_FILL_ALT,  1'b1, NA_CODE,       8'd255, 1'b0, 31'd19,         1'b1, 32'd101,       1'b0},
        '{NA_FILL_ALT,  1'b1, 32'h5555_5555, 8'hAA,  1'b0, 31'h2AAA_AAAA,  1'b0, 32'd0,         1'b0},
        '{NA_FILL_ALT,  1'b1, 32'h2AAA_AAAA, 8'h55,  1'b1, 31'h5555_5555,  1'b0, 32'd0,         1'b0},
        '{NA_SKIP,      1'b0, NA_CODE,       8'd9,   1'b0, 31'd20,         1'b1, NA_CODE,       1'b0},
        '{NA_SKIP,      1'b0, 32'd0,         8'd9,   1'b0, 31'd21,         1'b0, 32'd0,         1'b0}
    };

    grouped_running_sum_int_na_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .s_group     (s_group),
        .s_start_req (s_start_req),
        .s_slot      (s_slot),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_sum       (m_sum),
        .m_overflow  (m_overflow),
        .m_slot_out  (m_slot_out)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Applies one accepted beat to the predictor state and returns the expected result.
    function automatic sum_result_t advance_group_sum(input logic [VALUE_W-1:0] value,
                                                      input logic [GROUP_W-1:0] group,
                                                      input logic start,
                                                      input logic [SLOT_W-1:0] slot);
        sum_result_t        res;
        int                 g;
        logic [VALUE_W-1:0] base;
        logic               stuck;
        longint             acc;
        g = group_enable ? int'(group) : 0;
        if (g >= NUM_GROUPS)
            g = NUM_GROUPS - 1;
        if (start)
            grp_live = '0;
        base  = grp_live[g] ? grp_total[g] : '0;
        stuck = grp_live[g] && grp_missing[g];
        res.sum  = NA_CODE;
        res.ovf  = 1'b0;
        res.slot = slot;
        if (stuck) begin
            res.sum = NA_CODE;
        end else if (value == NA_CODE) begin
            if (na_policy == NA_PROPAGATE) begin
                grp_total[g]   = base;
                grp_missing[g] = 1'b1;
                grp_live[g]    = 1'b1;
            end else if (na_policy[1]) begin
                res.sum = base;
            end
        end else begin
            acc = $signed(base);
            acc = acc + $signed(value);
            if (acc > SUM_LIMIT || acc < -SUM_LIMIT) begin
                res.ovf = 1'b1;
            end else begin
                res.sum        = acc[VALUE_W-1:0];
                grp_total[g]   = acc[VALUE_W-1:0];
                grp_missing[g] = 1'b0;
                grp_live[g]    = 1'b1;
            end
        end
        return res;
    endfunction

    // Leaves s_valid high after acceptance so a following beat can go out back to back.
    task automatic send_beat(input logic [VALUE_W-1:0] value, input logic [GROUP_W-1:0] group,
                             input logic start, input logic [SLOT_W-1:0] slot,
                             input logic use_fixed, input sum_result_t fixed_res);
        sum_result_t res;
        s_valid     <= 1'b1;
        s_value     <= value;
        s_group     <= group;
        s_start_req <= start;
        s_slot      <= slot;
        do @(posedge aclk); while (!s_ready);
        res = advance_group_sum(value, group, start, slot);
        if (use_fixed)
            res = fixed_res;
        pending_sums.push_back(res);
        beats_sent++;
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_NA_MODE: na_policy    = data[1:0];
            CFG_GROUPED: group_enable = data[0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // Upper data bits are random; only the low bits of each register matter.
    task automatic program_regs(input logic [1:0] mode, input logic grp_on,
                                input bit with_junk, input logic [CFG_IDX_W-1:0] junk_idx);
        if (with_junk)
            write_reg(junk_idx, $urandom());
        write_reg(CFG_NA_MODE, {30'($urandom()), mode});
        write_reg(CFG_GROUPED, {31'($urandom()), grp_on});
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Receiver: segments of always-ready, coin-flip and mostly-stalled, plus requested hold-offs.
    initial begin
        int seg_mode;
        int seg_len;
        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
                holds_done++;
            end else begin
                seg_mode = $urandom_range(0, 2);
                seg_len  = $urandom_range(8, 60);
                repeat (seg_len) begin
                    case (seg_mode)
                        0:       m_ready <= 1'b1;
                        1:       m_ready <= 1'($urandom_range(0, 1));
                        default: m_ready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge aclk);
                    if (hold_off_req)
                        break;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_sums.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result beat: expected none, got sum %h ovf %b slot %h",
                         $time, m_sum, m_overflow, m_slot_out);
            end else begin
                oldest_sum = pending_sums.pop_front();
                results_checked++;
                if (oldest_sum.ovf)
                    overflow_seen++;
                else if (oldest_sum.sum == NA_CODE)
                    missing_seen++;
                if (m_sum !== oldest_sum.sum) begin
                    mismatch_count++;
                    $display("%0t: sum mismatch (slot %h): expected %h, got %h",
                             $time, oldest_sum.slot, oldest_sum.sum, m_sum);
                end
                if (m_overflow !== oldest_sum.ovf) begin
                    mismatch_count++;
                    $display("%0t: overflow mismatch (slot %h): expected %b, got %b",
                             $time, oldest_sum.slot, oldest_sum.ovf, m_overflow);
                end
                if (m_slot_out !== oldest_sum.slot) begin
                    mismatch_count++;
                    $display("%0t: slot mismatch: expected %h, got %h",
                             $time, oldest_sum.slot, m_slot_out);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("grouped_running_sum_int_na_core_tb: done, errors");
            $finish;
        end
    end

    initial begin
        stim_row_t          row;
        sum_result_t        fixed_res;
        logic [VALUE_W-1:0] val;
        logic [GROUP_W-1:0] grp;
        logic               st;
        int                 n;
        int                 seq_len;
        int                 focus;
        bit                 broken;
        int                 burst_left;
        int                 no_gap_left;
        int                 sel;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // A write to an unused register index must leave both registers alone.
        program_regs(NA_PROPAGATE, 1'b0, 1'b1, CFG_GROUPED + 8'd1);

        for (int i = 0; i < DIR_ROWS; i++) begin
            row = dir_rows[i];
            if (row.mode != na_policy || row.grp_en != group_enable) begin
                wait_results_drained();
                program_regs(row.mode, row.grp_en, 1'b0, CFG_NA_MODE);
            end
            fixed_res = '{row.sum, row.ovf, row.slot};
            send_beat(row.value, row.group, row.start, row.slot, row.typed, fixed_res);
        end

        burst_left  = $urandom_range(1, 20);
        no_gap_left = 0;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_results_drained();
            program_regs(2'(ph % 4), (ph < 4) ? 1'(ph % 2) : 1'(1 - ph % 2),
                         ($urandom_range(0, 2) == 0), 8'($urandom_range(2, 255)));
            n = 0;
            while (n < PHASE_ITEMS) begin
                // Mostly well-formed sequences opened by a start beat; some are left unopened.
                seq_len = $urandom_range(1, 40);
                focus   = $urandom_range(0, 255);
                broken  = ($urandom_range(0, 9) == 0);
                for (int k = 0; k < seq_len && n < PHASE_ITEMS; k++) begin
                    if (ph == 2 && n == 0) begin
                        hold_off_req = 1'b1;
                        no_gap_left  = 40;
                    end
                    st  = (k == 0 && !broken) || ($urandom_range(0, 49) == 0);
                    grp = ($urandom_range(0, 4) == 0) ? 8'($urandom()) :
                                                        8'(focus + $urandom_range(0, 3));
                    sel = $urandom_range(0, 99);
                    if (sel < 5) begin
                        val = NA_CODE;
                    end else if (sel < 15) begin
                        case ($urandom_range(0, 3))
                            0:       val = 32'h7FFF_FFFF;
                            1:       val = 32'h8000_0001;
                            2:       val = 32'h0000_0000;
                            default: val = 32'hFFFF_FFFF;
                        endcase
                    end else if (sel < 35) begin
                        val = $urandom();
                    end else begin
                        val = $urandom_range(0, 2000000) - 32'd1000000;
                    end
                    send_beat(val, grp, st, 31'($urandom()), 1'b0, '0);
                    n++;
                    if (ph == 3 && n == 60)
                        wait_results_drained();
                    if (no_gap_left > 0) begin
                        no_gap_left--;
                    end else if (ph != 5) begin
                        if (burst_left == 0) begin
                            s_valid <= 1'b0;
                            repeat ($urandom_range(1, 6)) @(posedge aclk);
                            burst_left = $urandom_range(1, 20);
                        end else begin
                            burst_left--;
                        end
                    end
                end
            end
        end

        wait_results_drained();
        repeat (8) @(posedge aclk);

        $display("Covered %0d beats and %0d checked results, %0d overflowed and %0d missing.",
                 beats_sent, results_checked, overflow_seen, missing_seen);
        $display("Used %0d register settings over %0d writes, with %0d long output hold-offs.",
                 settings_used, reg_writes, holds_done);
        if (mismatch_count == 0)
            $display("grouped_running_sum_int_na_core_tb: done, clean");
        else
            $display("grouped_running_sum_int_na_core_tb: done, errors");
        $finish;
    end

endmodule

>>> grouped_running_sum_int_na_core.f
rtl/core/grsum_pkg.sv
rtl/core/grsum_ctrl.sv
rtl/core/grsum_datapath.sv
rtl/core/grouped_running_sum_int_na_core.sv
rtl/core/grsum_checker.sv
verif/grouped_running_sum_int_na_core_tb.sv
